// File: src/krv_pkg.sv
package krv_pkg;

   // Default Newton step budget
   localparam int NEWTON_STEPS_DEF = 50;

   // Fixed-point constants
   localparam logic [30:0] ONE_Q30         = 31'h4000_0000;
   localparam logic [33:0] TWO_PI_Q28      = 34'd1686629713;
   localparam logic [33:0] INV_TWO_PI_Q32  = 34'd683565276;
   localparam logic [23:0] ECC_START_LIMIT = 24'd13421772;
   localparam logic [31:0] HALF_TURN       = 32'h8000_0000;
   localparam logic [29:0] EIGHTH_TURN     = 30'h2000_0000;
   localparam logic [30:0] QUARTER_TURN    = 31'h4000_0000;

   // Accumulator and output limits
   localparam logic signed [40:0] SUM_MAX = 41'sh0_7F_FFFF_FFFF;
   localparam logic signed [40:0] SUM_MIN = -41'sh0_80_0000_0000;
   localparam logic signed [39:0] OUT_MAX = 40'sh00_7FFF_FFFF;
   localparam logic signed [39:0] OUT_MIN = -40'sh00_8000_0000;

   // Divider step counts
   localparam logic [6:0] STEPS_PHASE = 7'd86;
   localparam logic [6:0] STEPS_DIV   = 7'd64;
   localparam logic [6:0] STEPS_SQRT  = 7'd31;

   // Polynomial term indexes: sine terms first, then cosine terms
   localparam logic [3:0] KIDX_SIN_LAST = 4'd4;
   localparam logic [3:0] KIDX_COS_LAST = 4'd10;

   typedef enum logic {
      DIV_MODE_DIV,
      DIV_MODE_SQRT
   } div_mode_type;

   typedef struct packed {
      logic         start;
      div_mode_type mode;
      logic [6:0]   steps;
   } div_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

   // Divisor k(k+1) of each Taylor term
   function automatic logic [7:0] term_div(input logic [3:0] kidx);
      logic [7:0] d;
      unique case (kidx)
         4'd0:    d = 8'd110;
         4'd1:    d = 8'd72;
         4'd2:    d = 8'd42;
         4'd3:    d = 8'd20;
         4'd4:    d = 8'd6;
         4'd5:    d = 8'd132;
         4'd6:    d = 8'd90;
         4'd7:    d = 8'd56;
         4'd8:    d = 8'd30;
         4'd9:    d = 8'd12;
         4'd10:   d = 8'd2;
         default: d = 8'd1;
      endcase
      return d;
   endfunction

   // floor(2^32 / k(k+1)) of each Taylor term
   function automatic logic [31:0] term_recip(input logic [3:0] kidx);
      logic [31:0] r;
      unique case (kidx)
         4'd0:    r = 32'(64'd4294967296 / 64'd110);
         4'd1:    r = 32'(64'd4294967296 / 64'd72);
         4'd2:    r = 32'(64'd4294967296 / 64'd42);
         4'd3:    r = 32'(64'd4294967296 / 64'd20);
         4'd4:    r = 32'(64'd4294967296 / 64'd6);
         4'd5:    r = 32'(64'd4294967296 / 64'd132);
         4'd6:    r = 32'(64'd4294967296 / 64'd90);
         4'd7:    r = 32'(64'd4294967296 / 64'd56);
         4'd8:    r = 32'(64'd4294967296 / 64'd30);
         4'd9:    r = 32'(64'd4294967296 / 64'd12);
         4'd10:   r = 32'(64'd4294967296 / 64'd2);
         default: r = 32'hFFFF_FFFF;
      endcase
      return r;
   endfunction

   // Signed quotient from magnitude, clamped to [-2^30, 2^30]
   function automatic logic signed [31:0] clamp_q30(input logic [63:0] mag, input logic neg);
      logic [31:0] m;
      m = (mag > 64'h4000_0000) ? 32'h4000_0000 : mag[31:0];
      return neg ? -signed'(m) : signed'(m);
   endfunction

   // Signed quotient from magnitude, clamped to the int32 range
   function automatic logic [31:0] clamp_i32(input logic [63:0] mag, input logic neg);
      logic [31:0] r;
      if (neg) begin
         r = (mag > 64'h8000_0000) ? 32'h8000_0000 : (32'h0 - mag[31:0]);
      end else begin
         r = (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
      end
      return r;
   endfunction

endpackage

// File: src/krv_mul.sv
module krv_mul (
   input  logic                clock,
   input  logic signed [33:0]  mul_a,
   input  logic signed [33:0]  mul_b,
   output logic signed [67:0]  prod
);

   logic signed [67:0] prod_ff;

   // Registered signed product
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   assign prod = prod_ff;

endmodule

// File: src/krv_div.sv
module krv_div (
   input  logic                 clock,
   input  logic                 reset,
   input  krv_pkg::div_cmd_type cmd,
   input  logic [85:0]          dividend,
   input  logic [31:0]          divisor,
   output krv_pkg::div_sts_type sts,
   output logic [63:0]          quot
);

   import krv_pkg::*;

   logic         busy_ff;
   logic         done_ff;
   logic [6:0]   cnt_ff;
   div_mode_type mode_ff;
   logic [85:0]  num_ff;
   logic [31:0]  den_ff;
   logic [34:0]  rem_ff;
   logic [63:0]  quot_ff;

   logic [34:0]  cand;
   logic [34:0]  subt;
   logic [35:0]  trial;
   logic         fits;

   // One restoring step: a quotient bit or a root bit
   always_comb begin
      if (mode_ff == DIV_MODE_SQRT) begin
         cand = {rem_ff[32:0], num_ff[85:84]};
         subt = {quot_ff[32:0], 2'b01};
      end else begin
         cand = {rem_ff[33:0], num_ff[85]};
         subt = {3'b000, den_ff};
      end
      trial = {1'b0, cand} - {1'b0, subt};
      fits  = !trial[35];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= cmd.steps;
            mode_ff <= cmd.mode;
            num_ff  <= dividend;
            den_ff  <= divisor;
            rem_ff  <= '0;
            quot_ff <= '0;
         end else if (busy_ff) begin
            rem_ff  <= fits ? trial[34:0] : cand;
            quot_ff <= {quot_ff[62:0], fits};
            num_ff  <= (mode_ff == DIV_MODE_SQRT) ? {num_ff[83:0], 2'b00}
                                                  : {num_ff[84:0], 1'b0};
            cnt_ff  <= cnt_ff - 7'd1;
            if (cnt_ff == 7'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign quot     = quot_ff;

`ifndef SYNTHESIS
   // A start is only issued to an idle unit
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !busy_ff)
      else $error("divider started while busy");

   // Completion follows the last step of a run
   a_done_end: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff) && !busy_ff)
      else $error("divider done without a finished run");

   // A run never counts below one step
   a_cnt_live: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff != 7'd0)
      else $error("divider busy with empty count");
`endif

endmodule

// File: src/keplerian_radial_velocity.sv
// Keplerian radial velocity: each beat on req carries one sample time and one planet's
// orbit; the block solves Kepler's equation by Newton steps and adds that planet's
// velocity to a running sum, and a beat with tlast high closes the sum and sends it,
// saturated to Q16.16, as one beat on rsp. Items are taken one at a time: req_tready is
// high only while the block is idle and out of reset. An item runs up to NEWTON_STEPS
// Newton steps, fewer once a step comes out zero; a zero period skips the phase
// division, and a closing beat also waits while the previous sum is still pending on
// rsp. The work is shared by the one 34x34 multiplier, which works each sine and cosine
// pair as Taylor series of eleven terms in all, five for the sine and six for the
// cosine, and by the bit-serial divider/square-root unit, which runs the orbit phase,
// every Newton step, each true-anomaly quotient and the square root. A finished sum
// waits in the output register, so the next item is taken while it is still pending.
module keplerian_radial_velocity #(
   parameter int NEWTON_STEPS = krv_pkg::NEWTON_STEPS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // sample_time[47:0], orbit_period[79:48], orbit_phase[111:80], eccentricity[135:112],
   // periastron_angle[167:136], semi_amplitude[190:168], zero[191]
   input  logic [191:0] req_tdata,
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // radial_velocity[31:0]
   output logic [31:0]  rsp_tdata
);

   import krv_pkg::*;

   localparam int IW = $clog2(NEWTON_STEPS);

   typedef enum logic [5:0] {
      S_IDLE, S_MA, S_MA_W, S_INIT,
      S_SC_INIT, S_SC_XR, S_SC_X2, S_SC_X2W, S_SC_T1, S_SC_T2, S_SC_T3, S_SC_T4,
      S_SC_S0, S_SC_S0W, S_SC_FIN,
      S_N_A, S_N_B, S_N_C, S_N_D, S_N_W, S_N_E,
      S_P_SW, S_P_A, S_P_B, S_P_C, S_P_CW, S_P_D, S_P_DW, S_P_E, S_P_F, S_P_FW,
      S_P_G, S_P_H, S_P_I, S_P_J, S_P_K
   } state_type;

   typedef enum logic [1:0] {
      RET_NEWTON,
      RET_POST_E,
      RET_POST_W
   } ret_type;

   state_type           state_ff;
   ret_type             ret_ff;
   logic                rsp_valid_ff;
   logic [31:0]         out_ff;
   logic signed [39:0]  acc_ff;

   // Item fields
   logic [47:0]         t_ff;
   logic [31:0]         per_ff;
   logic [23:0]         ecc_ff;
   logic [31:0]         w_ff;
   logic [22:0]         k_ff;
   logic                last_ff;

   // Kepler solve
   logic [31:0]         m_ff;
   logic [31:0]         ea_ff;
   logic [IW-1:0]       iter_ff;
   logic signed [31:0]  es_ff;
   logic [31:0]         dv_ff;
   logic                neg_ff;

   // Sine/cosine routine
   logic [31:0]         sc_ang_ff;
   logic                sc_swap_ff;
   logic [29:0]         sc_x_ff;
   logic [29:0]         xr_ff;
   logic [29:0]         x2_ff;
   logic [30:0]         pt_ff;
   logic [30:0]         y_ff;
   logic [30:0]         q0_ff;
   logic [30:0]         s0p_ff;
   logic [3:0]          kidx_ff;
   logic signed [31:0]  sin_ff;
   logic signed [31:0]  cos_ff;

   // Velocity term
   logic signed [31:0]  se_ff;
   logic signed [31:0]  ce_ff;
   logic [30:0]         sq_ff;
   logic signed [31:0]  cf_ff;
   logic signed [31:0]  sf_ff;
   logic signed [63:0]  prod1_ff;
   logic signed [33:0]  sum_ff;

   // Shared units
   logic signed [33:0]  mul_a;
   logic signed [33:0]  mul_b;
   logic signed [67:0]  mul_p;
   div_cmd_type         div_cmd;
   div_sts_type         div_sts;
   logic [85:0]         div_dividend;
   logic [31:0]         div_divisor;
   logic [63:0]         div_quot;

   // Combinational helpers
   logic signed [33:0]  ecc_s;
   logic [29:0]         sc_r;
   logic                sc_near;
   logic [29:0]         xr_new;
   logic [30:0]         y_new;
   logic [30:0]         q0_new;
   logic [7:0]          kd;
   logic [31:0]         rem_t;
   logic [30:0]         pt_new;
   logic [30:0]         s0u;
   logic [30:0]         c0u;
   logic signed [31:0]  s0s;
   logic signed [31:0]  c0s;
   logic signed [31:0]  sin_new;
   logic signed [31:0]  cos_new;
   logic signed [33:0]  es_a;
   logic signed [31:0]  ec_sh;
   logic signed [33:0]  dv_wide;
   logic [31:0]         dv_new;
   logic signed [31:0]  ang_diff;
   logic signed [32:0]  fv;
   logic signed [32:0]  cf_num;
   logic signed [32:0]  sf_num;
   logic signed [32:0]  div_num;
   logic [32:0]         div_abs;
   logic [48:0]         rad49;
   logic [31:0]         step;
   logic [31:0]         ea_next;
   logic [31:0]         ea_start;
   logic signed [63:0]  cross_diff;
   logic signed [33:0]  ecw;
   logic signed [33:0]  sum_new;
   logic signed [40:0]  term;
   logic signed [40:0]  acc_sum;
   logic signed [39:0]  acc_new;
   logic [31:0]         out_new;
   logic                k_go;

   krv_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (mul_p)
   );

   krv_div u_div (
      .clock    (clock),
      .reset    (reset),
      .cmd      (div_cmd),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .sts      (div_sts),
      .quot     (div_quot)
   );

   // Sine/cosine datapath
   always_comb begin
      ecc_s   = signed'({10'b0, ecc_ff});
      sc_r    = sc_ang_ff[29:0];
      sc_near = (sc_r <= EIGHTH_TURN);
      xr_new  = mul_p[59:30];
      y_new   = mul_p[60:30];
      q0_new  = mul_p[62:32];
      kd      = term_div(kidx_ff);
      rem_t   = {1'b0, y_ff} - mul_p[31:0];
      pt_new  = ONE_Q30 - (q0_ff + 31'(rem_t >= {24'b0, kd}));
      s0u     = sc_swap_ff ? pt_ff : s0p_ff;
      c0u     = sc_swap_ff ? s0p_ff : pt_ff;
      s0s     = signed'({1'b0, s0u});
      c0s     = signed'({1'b0, c0u});
      unique case (sc_ang_ff[31:30])
         2'd0: begin sin_new = s0s;  cos_new = c0s;  end
         2'd1: begin sin_new = c0s;  cos_new = -s0s; end
         2'd2: begin sin_new = -s0s; cos_new = -c0s; end
         2'd3: begin sin_new = -c0s; cos_new = s0s;  end
         default: begin sin_new = s0s; cos_new = c0s; end
      endcase
   end

   // Newton step and velocity term datapath
   always_comb begin
      es_a     = 34'(mul_p >>> 22);
      ec_sh    = 32'(mul_p >>> 24);
      dv_wide  = 34'sh4000_0000 - 34'(ec_sh);
      dv_new   = dv_wide[31:0];
      ang_diff = signed'(ea_ff - m_ff);
      fv       = 33'(ang_diff) - 33'(es_ff);
      cf_num   = 33'(ce_ff) - signed'({3'b0, ecc_ff, 6'b0});
      sf_num   = 33'(mul_p >>> 30);
      unique case (state_ff)
         S_N_D:   div_num = fv;
         S_P_D:   div_num = cf_num;
         default: div_num = sf_num;
      endcase
      div_abs  = div_num[32] ? 33'(-div_num) : 33'(div_num);
      rad49    = 49'h1_0000_0000_0000 - {1'b0, mul_p[47:0]};
      step     = clamp_i32(div_quot, neg_ff);
      ea_next  = ea_ff - step;
      ea_start = (ecc_ff > ECC_START_LIMIT) ? HALF_TURN : m_ff;
      cross_diff = prod1_ff - 64'(mul_p);
      ecw      = 34'(mul_p >>> 24);
      sum_new  = sum_ff + ecw;
      term     = 41'(mul_p >>> 30);
      acc_sum  = 41'(acc_ff) + term;
      if (acc_sum > SUM_MAX) begin
         acc_new = SUM_MAX[39:0];
      end else if (acc_sum < SUM_MIN) begin
         acc_new = SUM_MIN[39:0];
      end else begin
         acc_new = acc_sum[39:0];
      end
      if (acc_new > OUT_MAX) begin
         out_new = 32'h7FFF_FFFF;
      end else if (acc_new < OUT_MIN) begin
         out_new = 32'h8000_0000;
      end else begin
         out_new = acc_new[31:0];
      end
      k_go = !last_ff || !rsp_valid_ff || rsp_tready;
   end

   // Multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_SC_XR: begin mul_a = signed'({4'b0, sc_x_ff}); mul_b = signed'(TWO_PI_Q28); end
         S_SC_X2: begin mul_a = signed'({4'b0, xr_new}); mul_b = signed'({4'b0, xr_new}); end
         S_SC_T1: begin mul_a = signed'({4'b0, x2_ff}); mul_b = signed'({3'b0, pt_ff}); end
         S_SC_T2: begin
            mul_a = signed'({3'b0, y_new});
            mul_b = signed'({2'b0, term_recip(kidx_ff)});
         end
         S_SC_T3: begin mul_a = signed'({3'b0, q0_new}); mul_b = signed'({26'b0, kd}); end
         S_SC_S0: begin mul_a = signed'({4'b0, xr_ff}); mul_b = signed'({3'b0, pt_ff}); end
         S_N_A:   begin mul_a = ecc_s; mul_b = 34'(sin_ff); end
         S_N_B:   begin mul_a = es_a;  mul_b = signed'(INV_TWO_PI_Q32); end
         S_N_C:   begin mul_a = ecc_s; mul_b = 34'(cos_ff); end
         S_P_A:   begin mul_a = ecc_s; mul_b = 34'(ce_ff); end
         S_P_B:   begin mul_a = ecc_s; mul_b = ecc_s; end
         S_P_E:   begin mul_a = signed'({3'b0, sq_ff}); mul_b = 34'(se_ff); end
         S_P_G:   begin mul_a = 34'(cos_ff); mul_b = 34'(cf_ff); end
         S_P_H:   begin mul_a = 34'(sin_ff); mul_b = 34'(sf_ff); end
         S_P_I:   begin mul_a = ecc_s; mul_b = 34'(cos_ff); end
         S_P_J:   begin mul_a = signed'({11'b0, k_ff}); mul_b = sum_new; end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   // Divider command select
   always_comb begin
      div_cmd.start = 1'b0;
      div_cmd.mode  = DIV_MODE_DIV;
      div_cmd.steps = STEPS_DIV;
      div_dividend  = {1'b0, div_abs, 52'b0};
      div_divisor   = dv_ff;
      unique case (state_ff)
         S_MA: begin
            div_cmd.start = 1'b1;
            div_cmd.steps = STEPS_PHASE;
            div_dividend  = {t_ff, 38'b0};
            div_divisor   = per_ff;
         end
         S_N_D: begin
            div_cmd.start = 1'b1;
            div_divisor   = dv_new;
         end
         S_P_C: begin
            div_cmd.start = 1'b1;
            div_cmd.mode  = DIV_MODE_SQRT;
            div_cmd.steps = STEPS_SQRT;
            div_dividend  = {1'b0, rad49, 36'b0};
         end
         S_P_D, S_P_F: begin
            div_cmd.start = 1'b1;
         end
         default: begin
            div_cmd.start = 1'b0;
         end
      endcase
   end

   // Sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         acc_ff       <= '0;
         iter_ff      <= '0;
      end else begin
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  t_ff    <= req_tdata[47:0];
                  per_ff  <= req_tdata[79:48];
                  m_ff    <= req_tdata[111:80];
                  ecc_ff  <= req_tdata[135:112];
                  w_ff    <= req_tdata[167:136];
                  k_ff    <= req_tdata[190:168];
                  last_ff <= req_tlast;
                  state_ff <= (req_tdata[79:48] == 32'd0) ? S_INIT : S_MA;
               end
            end
            S_MA: state_ff <= S_MA_W;
            S_MA_W: begin
               if (div_sts.done) begin
                  m_ff     <= m_ff + div_quot[31:0];
                  state_ff <= S_INIT;
               end
            end
            S_INIT: begin
               ea_ff     <= ea_start;
               sc_ang_ff <= ea_start;
               iter_ff   <= '0;
               ret_ff    <= RET_NEWTON;
               state_ff  <= S_SC_INIT;
            end
            // Sine and cosine of sc_ang_ff
            S_SC_INIT: begin
               sc_swap_ff <= !sc_near;
               sc_x_ff    <= sc_near ? sc_r : 30'(QUARTER_TURN - {1'b0, sc_r});
               state_ff   <= S_SC_XR;
            end
            S_SC_XR: state_ff <= S_SC_X2;
            S_SC_X2: begin
               xr_ff    <= xr_new;
               state_ff <= S_SC_X2W;
            end
            S_SC_X2W: begin
               x2_ff    <= mul_p[59:30];
               pt_ff    <= ONE_Q30;
               kidx_ff  <= '0;
               state_ff <= S_SC_T1;
            end
            S_SC_T1: state_ff <= S_SC_T2;
            S_SC_T2: begin
               y_ff     <= y_new;
               state_ff <= S_SC_T3;
            end
            S_SC_T3: begin
               q0_ff    <= q0_new;
               state_ff <= S_SC_T4;
            end
            S_SC_T4: begin
               pt_ff   <= pt_new;
               kidx_ff <= kidx_ff + 4'd1;
               if (kidx_ff == KIDX_SIN_LAST) begin
                  state_ff <= S_SC_S0;
               end else if (kidx_ff == KIDX_COS_LAST) begin
                  state_ff <= S_SC_FIN;
               end else begin
                  state_ff <= S_SC_T1;
               end
            end
            S_SC_S0: state_ff <= S_SC_S0W;
            S_SC_S0W: begin
               s0p_ff   <= mul_p[60:30];
               pt_ff    <= ONE_Q30;
               state_ff <= S_SC_T1;
            end
            S_SC_FIN: begin
               sin_ff <= sin_new;
               cos_ff <= cos_new;
               unique case (ret_ff)
                  RET_NEWTON: state_ff <= S_N_A;
                  RET_POST_E: state_ff <= S_P_SW;
                  RET_POST_W: state_ff <= S_P_A;
                  default:    state_ff <= S_N_A;
               endcase
            end
            // Newton step
            S_N_A: state_ff <= S_N_B;
            S_N_B: state_ff <= S_N_C;
            S_N_C: begin
               es_ff    <= 32'(mul_p >>> 32);
               state_ff <= S_N_D;
            end
            S_N_D: begin
               dv_ff    <= dv_new;
               neg_ff   <= fv[32];
               state_ff <= S_N_W;
            end
            S_N_W: begin
               if (div_sts.done) begin
                  state_ff <= S_N_E;
               end
            end
            S_N_E: begin
               ea_ff     <= ea_next;
               sc_ang_ff <= ea_next;
               state_ff  <= S_SC_INIT;
               if (step == 32'd0 || iter_ff == IW'(NEWTON_STEPS - 1)) begin
                  ret_ff <= RET_POST_E;
               end else begin
                  ret_ff  <= RET_NEWTON;
                  iter_ff <= iter_ff + IW'(1);
               end
            end
            // True anomaly and velocity term
            S_P_SW: begin
               se_ff     <= sin_ff;
               ce_ff     <= cos_ff;
               sc_ang_ff <= w_ff;
               ret_ff    <= RET_POST_W;
               state_ff  <= S_SC_INIT;
            end
            S_P_A: state_ff <= S_P_B;
            S_P_B: begin
               dv_ff    <= dv_new;
               state_ff <= S_P_C;
            end
            S_P_C: state_ff <= S_P_CW;
            S_P_CW: begin
               if (div_sts.done) begin
                  sq_ff    <= div_quot[30:0];
                  state_ff <= S_P_D;
               end
            end
            S_P_D: begin
               neg_ff   <= cf_num[32];
               state_ff <= S_P_DW;
            end
            S_P_DW: begin
               if (div_sts.done) begin
                  cf_ff    <= clamp_q30(div_quot, neg_ff);
                  state_ff <= S_P_E;
               end
            end
            S_P_E: state_ff <= S_P_F;
            S_P_F: begin
               neg_ff   <= sf_num[32];
               state_ff <= S_P_FW;
            end
            S_P_FW: begin
               if (div_sts.done) begin
                  sf_ff    <= clamp_q30(div_quot, neg_ff);
                  state_ff <= S_P_G;
               end
            end
            S_P_G: state_ff <= S_P_H;
            S_P_H: begin
               prod1_ff <= 64'(mul_p);
               state_ff <= S_P_I;
            end
            S_P_I: begin
               sum_ff   <= 34'(cross_diff >>> 30);
               state_ff <= S_P_J;
            end
            S_P_J: begin
               sum_ff   <= sum_new;
               state_ff <= S_P_K;
            end
            S_P_K: begin
               if (k_go) begin
                  if (last_ff) begin
                     rsp_valid_ff <= 1'b1;
                     out_ff       <= out_new;
                     acc_ff       <= '0;
                  end else begin
                     acc_ff <= acc_new;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE) && !reset;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = out_ff;

`ifndef SYNTHESIS
   // The divider is never left running while the block is idle
   a_idle_div: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !div_sts.busy)
      else $error("divider busy while idle");

   // Division results land only in a state that waits for them
   a_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_sts.done |-> (state_ff == S_MA_W || state_ff == S_N_W || state_ff == S_P_CW ||
                        state_ff == S_P_DW || state_ff == S_P_FW))
      else $error("divider result with no waiting state");

   // Newton step counter stays within the budget
   a_iter_cap: assert property (@(posedge clock) disable iff (reset)
      iter_ff <= IW'(NEWTON_STEPS - 1))
      else $error("Newton step count overrun");

   // A result beat is raised only by a closing planet
   a_rsp_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> last_ff && acc_ff == '0)
      else $error("result without closing planet");
`endif

endmodule

// File: tb/tb_keplerian_radial_velocity.sv
module tb_keplerian_radial_velocity;
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint Q30       = 64'sd1073741824;
   localparam longint ACC_TOP   = (64'sd1 <<< 39) - 1;
   localparam longint ACC_BOT   = -(64'sd1 <<< 39);
   localparam longint I32_TOP   = 64'sd2147483647;
   localparam longint I32_BOT   = -64'sd2147483648;
   localparam int     STALL_LIMIT = 60000;
   localparam int     N_RANDOM    = 230;

   // one planet term as it travels on req
   typedef struct {
      logic [47:0] sample_time;
      logic [31:0] orbit_period;
      logic [31:0] orbit_phase;
      logic [23:0] eccentricity;
      logic [31:0] periastron_angle;
      logic [22:0] semi_amplitude;
      logic        last_planet;
   } planet_type;

   // directed row: a planet plus an optional hand-worked velocity
   typedef struct {
      planet_type  p;
      logic        known;
      logic [31:0] velocity;
   } row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [191:0] req_tdata = '0;
   logic         req_tlast = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [31:0]  rsp_tdata;

   logic [31:0]  velocity_q[$];
   longint       velocity_acc;
   int           errors = 0;
   int           beats_in = 0;
   int           sums_out = 0;
   int           idle_cycles = 0;
   int           out_stall_mode = 0;
   row_type      rows[$];

   keplerian_radial_velocity dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------- predictor ----------------

   // Taylor sine/cosine on at most an eighth of a turn, Q30
   function automatic void taylor_sincos(input logic [31:0] x, output longint s,
                                         output longint c);
      logic [63:0] xr, x2, t;
      int          k;
      xr = (64'(x) * 64'd1686629713) >> 30;
      x2 = (xr * xr) >> 30;
      t = 64'(Q30);
      for (k = 10; k >= 2; k -= 2)
         t = 64'(Q30) - ((x2 * t) >> 30) / 64'(k * (k + 1));
      s = longint'((xr * t) >> 30);
      t = 64'(Q30);
      for (k = 11; k >= 1; k -= 2)
         t = 64'(Q30) - ((x2 * t) >> 30) / 64'(k * (k + 1));
      c = longint'(t);
   endfunction

   // full-turn sine/cosine by quadrant folding
   function automatic void turn_sincos(input logic [31:0] a, output longint s,
                                       output longint c);
      logic [31:0] r;
      longint      s0, c0;
      r = {2'b00, a[29:0]};
      if (r <= 32'h2000_0000) begin
         taylor_sincos(r, s0, c0);
      end else begin
         taylor_sincos(32'h4000_0000 - r, c0, s0);
      end
      case (a[31:30])
         2'd0: begin s = s0;  c = c0;  end
         2'd1: begin s = c0;  c = -s0; end
         2'd2: begin s = -s0; c = -c0; end
         default: begin s = -c0; c = s0; end
      endcase
   endfunction

   function automatic logic [63:0] int_sqrt(input logic [63:0] v);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // eccentric anomaly by Newton iteration, angles in binary turns
   function automatic logic [31:0] newton_anomaly(input logic [31:0] m, input longint e);
      logic [31:0] ea, d;
      longint      s, c, diff, es, fv, dv, stp;
      ea = (e > 64'sd13421772) ? 32'h8000_0000 : m;
      for (int i = 0; i < krv_pkg::NEWTON_STEPS_DEF; i++) begin
         turn_sincos(ea, s, c);
         d = ea - m;
         diff = d[31] ? longint'(d) - (64'sd1 <<< 32) : longint'(d);
         es = (((e * s) >>> 22) * 64'sd683565276) >>> 32;
         fv = diff - es;
         dv = Q30 - ((e * c) >>> 24);
         stp = (fv * Q30) / dv;
         if (stp < I32_BOT) stp = I32_BOT;
         if (stp > I32_TOP) stp = I32_TOP;
         if (stp == 0) break;
         ea = ea - stp[31:0];
      end
      return ea;
   endfunction

   function automatic longint clip(input longint x, input longint lo, input longint hi);
      return (x < lo) ? lo : ((x > hi) ? hi : x);
   endfunction

   // add one planet to the running sum; returns 1 with the velocity when it closes
   function automatic bit planet_velocity(input planet_type p, output logic [31:0] v);
      logic [63:0] r0, q;
      logic [31:0] frac, ea;
      longint      e, k, se, ce, sw, cw, dv, sq, cf, sf, sum, term;
      frac = 0;
      e = longint'(p.eccentricity);
      k = longint'(p.semi_amplitude);
      if (p.orbit_period != 0) begin
         r0 = {10'd0, p.sample_time, 6'd0} % 64'(p.orbit_period);
         q  = (r0 << 32) / 64'(p.orbit_period);
         frac = q[31:0];
      end
      ea = newton_anomaly(frac + p.orbit_phase, e);
      turn_sincos(ea, se, ce);
      turn_sincos(p.periastron_angle, sw, cw);
      dv = Q30 - ((e * ce) >>> 24);
      sq = longint'(int_sqrt(((64'd1 << 48) - 64'(e * e)) << 12));
      cf = clip(((ce - (e <<< 6)) * Q30) / dv, -Q30, Q30);
      sf = clip((((sq * se) >>> 30) * Q30) / dv, -Q30, Q30);
      sum = ((cw * cf - sw * sf) >>> 30) + ((e * cw) >>> 24);
      term = (k * sum) >>> 30;
      velocity_acc = clip(velocity_acc + term, ACC_BOT, ACC_TOP);
      v = 32'(clip(velocity_acc, I32_BOT, I32_TOP));
      if (!p.last_planet) return 0;
      velocity_acc = 0;
      return 1;
   endfunction

   // ---------------- driver ----------------

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 120);
   endfunction

   task automatic send_planet(input planet_type p, input logic known,
                              input logic [31:0] hand);
      int          gap;
      logic [31:0] v;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, p.semi_amplitude, p.periastron_angle, p.eccentricity,
                     p.orbit_phase, p.orbit_period, p.sample_time};
      req_tlast  <= p.last_planet;
      do @(posedge clock); while (!(req_tvalid && req_tready));
      beats_in++;
      if (planet_velocity(p, v)) begin
         if (known && v !== hand) begin
            $error("radial_velocity: expected %h, predictor gives %h", hand, v);
            errors++;
         end
         velocity_q.push_back(v);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (velocity_q.size() != 0) @(posedge clock);
   endtask

   function automatic planet_type random_planet(input logic last);
      planet_type p;
      int         sel;
      p.sample_time = {16'($urandom), 32'($urandom)};
      sel = $urandom_range(0, 19);
      if (sel == 0)      p.orbit_period = 0;
      else if (sel == 1) p.orbit_period = $urandom;
      else               p.orbit_period = $urandom_range(419430, 32'd4194304000);
      p.orbit_phase = $urandom;
      sel = $urandom_range(0, 9);
      if (sel < 4)       p.eccentricity = 24'($urandom_range(0, 4194304));
      else if (sel < 8)  p.eccentricity = 24'($urandom);
      else               p.eccentricity = 24'hFFFFFF - 24'($urandom_range(0, 4095));
      p.periastron_angle = $urandom;
      sel = $urandom_range(0, 9);
      if (sel == 0)      p.semi_amplitude = 23'($urandom);
      else               p.semi_amplitude = 23'($urandom_range(6554, 6553600));
      p.last_planet = last;
      return p;
   endfunction

   function automatic planet_type mk(input logic [47:0] t, input logic [31:0] per,
                                     input logic [31:0] ph, input logic [23:0] e,
                                     input logic [31:0] w, input logic [22:0] k,
                                     input logic last);
      planet_type p;
      p.sample_time = t; p.orbit_period = per; p.orbit_phase = ph;
      p.eccentricity = e; p.periastron_angle = w; p.semi_amplitude = k;
      p.last_planet = last;
      return p;
   endfunction

   // ---------------- result side ----------------

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            sums_out++;
            if (velocity_q.size() == 0) begin
               $error("radial_velocity beat with nothing expected: %h", rsp_tdata);
               errors++;
            end else begin
               if (rsp_tdata !== velocity_q[0]) begin
                  $error("radial_velocity: expected %h, got %h", velocity_q[0], rsp_tdata);
                  errors++;
               end
               void'(velocity_q.pop_front());
            end
         end
         if ($urandom_range(0, 299) == 0) out_stall_mode = $urandom_range(0, 2);
         case (out_stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 3) != 0);
            default: rsp_tready <= ($urandom_range(0, 40) == 0);
         endcase
      end
   end

   // watchdog: cycles with no beat on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("watchdog expired with %0d sums pending", velocity_q.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // ---------------- stimulus ----------------

   initial begin
      planet_type p;
      int         n;
      velocity_acc = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows; the first two are worked by hand (M = E = 0, K = 1.0)
      rows.push_back('{mk(0, 0, 0, 0, 0, 65536, 1), 1'b1, 32'h0001_0000});
      rows.push_back('{mk(0, 0, 0, 0, 32'h8000_0000, 65536, 1), 1'b1, 32'hFFFF_0000});
      rows.push_back('{mk('1, '1, '1, '1, '1, '1, 1), 1'b0, 0});
      rows.push_back('{mk('1, 419430, 0, 0, 0, 6554, 1), 1'b0, 0});
      rows.push_back('{mk(48'h1234_5678_9ABC, 32'd4194304000, 0, 0, 0, 6553600, 1), 1'b0, 0});
      rows.push_back('{mk(0, 0, 32'h8000_0000, 24'd13421772, 0, 65536, 1), 1'b0, 0});
      rows.push_back('{mk(0, 0, 32'h4000_0000, 24'd13421773, 0, 65536, 1), 1'b0, 0});
      rows.push_back('{mk(0, 0, 32'h0100_0000, 24'hFFFFFF, 32'h4000_0000, 65536, 1), 1'b0, 0});
      rows.push_back('{mk(0, 0, 32'hFF00_0000, 24'hFFFFFF, 32'hC000_0000, '1, 1), 1'b0, 0});
      rows.push_back('{mk(0, 0, 32'h2000_0000, 24'h800000, 32'h2000_0000, '1, 1), 1'b0, 0});
      rows.push_back('{mk(0, 0, 32'h6000_0000, 24'hF00000, 32'hE000_0000, 1000, 1), 1'b0, 0});
      // three planets summed into one velocity
      rows.push_back('{mk(48'd6553600, 32'd41943040, 0, 24'h100000, 0, 300000, 0), 1'b0, 0});
      rows.push_back('{mk(48'd6553600, 32'd4194304, 32'h1000_0000, 24'h400000,
                          32'h5000_0000, 400000, 0), 1'b0, 0});
      rows.push_back('{mk(48'd6553600, 32'd419430, 32'h9000_0000, 24'hC00000,
                          32'hA000_0000, 500000, 1), 1'b0, 0});
      rows.push_back('{mk(48'h0000_0001_0000, 32'hFFFF_FFFF, 32'h0000_0001, 24'd1,
                          32'h0000_0001, 23'd1, 1), 1'b0, 0});
      rows.push_back('{mk(48'hAAAA_AAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 24'h555555,
                          32'h5555_5555, 23'h2AAAAA, 1), 1'b0, 0});
      rows.push_back('{mk(48'h5555_5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 24'hAAAAAA,
                          32'hAAAA_AAAA, 23'h555555, 1), 1'b0, 0});
      foreach (rows[i]) send_planet(rows[i].p, rows[i].known, rows[i].velocity);

      // hold the sender until every sum is back
      drain();

      // long sums that drive the output into saturation, both signs
      for (int sgn = 0; sgn < 2; sgn++) begin
         for (int i = 0; i < 150; i++) begin
            p = mk(48'($urandom), 0, 0, 24'd13421772, sgn ? 32'h8000_0000 : 32'h0,
                   23'h7FFFFF, i == 149);
            send_planet(p, 1'b0, 0);
         end
      end

      // random groups of one to five planets per sum
      n = 0;
      while (n < N_RANDOM) begin
         int group;
         group = $urandom_range(1, 5);
         for (int g = 0; g < group; g++) begin
            send_planet(random_planet(g == group - 1), 1'b0, 0);
            n++;
         end
         if (n > N_RANDOM / 2 && n <= N_RANDOM / 2 + 5) drain();
      end

      // tail: wait for the last sums, then a short quiet spell
      drain();
      repeat (500) @(posedge clock);
      $display("sent %0d planet beats, checked %0d velocity sums", beats_in, sums_out);
      $display("covered zero and extreme periods, e up to 1, both start points, saturation");
      if (errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
